// ----- design/qmeu_pkg.sv -----
package qmeu_pkg;

  typedef enum logic [4:0] {
    OP_ADD        = 5'd0,
    OP_SUB        = 5'd1,
    OP_MUL        = 5'd2,
    OP_DIV        = 5'd3,
    OP_MOD        = 5'd4,
    OP_POP_REG    = 5'd5,
    OP_PUSH_REG   = 5'd6,
    OP_PRINT_Q    = 5'd7,
    OP_PRINT_REG  = 5'd8,
    OP_CHAR_Q     = 5'd9,
    OP_CHAR_REG   = 5'd10,
    OP_JUMP       = 5'd11,
    OP_JZ         = 5'd12,
    OP_JEQ        = 5'd13,
    OP_JGT        = 5'd14,
    OP_PUSH_CONST = 5'd15,
    OP_QUIT       = 5'd16,
    OP_NOP        = 5'd17
  } op_t;

  localparam int REG_COUNT = 26;
  localparam logic [15:0] BYTE_MASK = 16'd255;

  typedef struct packed {
    logic [4:0]  operation;
    logic [4:0]  first_register;
    logic [4:0]  second_register;
    logic [15:0] immediate_value;
  } in_word_t;

  typedef struct packed {
    logic        print_valid;
    logic        print_as_char;
    logic [15:0] print_value;
    logic        branch_taken;
    logic        halt;
    logic        queue_error;
  } out_word_t;

  // Classified instruction passed from the front end to the back end.
  typedef struct packed {
    logic [1:0]  pops;
    logic        push;
    logic        arith;
    logic [4:0]  operation;
    logic [4:0]  dest_reg;
    logic        dest_ok;
    logic [15:0] reg_a;
    logic [15:0] push_value;
    logic        branch_taken;
    logic        halt;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP1,
    ST_POP2,
    ST_DIV,
    ST_PUSH,
    ST_DONE
  } state_t;

endpackage

// ----- design/queue_machine_execute_unit.sv -----
// Executes one decoded queue machine instruction per input word and returns
// one result word for each. A front end reads the register file and decides
// jumps; a back end works the value queue through a memory with one
// registered read port. An instruction without queue access is quickest,
// then a single pop or push, then add, subtract and multiply, and divide or
// modulo slowest, as the divider works one quotient bit per cycle; a stalled
// result word holds the next instruction back. Instructions run one at a
// time, since each may write a register the next one reads.
module queue_machine_execute_unit #(
  parameter int QUEUE_DEPTH = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qmeu_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output qmeu_pkg::out_word_t out_word
);
  import qmeu_pkg::*;

  logic        cmd_valid, cmd_take, wb_en;
  cmd_t        cmd;
  logic [4:0]  wb_reg;
  logic [15:0] wb_value;

  qmeu_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .wb_en(wb_en), .wb_reg(wb_reg), .wb_value(wb_value),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  qmeu_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd(cmd), .wb_en(wb_en), .wb_reg(wb_reg), .wb_value(wb_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

endmodule

// ----- design/qmeu_front.sv -----
module qmeu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  qmeu_pkg::in_word_t in_word,
  input  logic              wb_en,
  input  logic [4:0]        wb_reg,
  input  logic [15:0]       wb_value,
  output logic              cmd_valid,
  input  logic              cmd_take,
  output qmeu_pkg::cmd_t    cmd
);
  import qmeu_pkg::*;

  logic [15:0] regs_r [REG_COUNT];
  logic [15:0] ra, rb;
  logic        full_r, full_nxt;
  logic        busy_r, busy_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic        acc;

  // One instruction is in flight at a time, since a later one may read
  // a register that this one writes.
  assign in_stall  = full_r | busy_r;
  assign acc       = in_valid & ~in_stall;
  assign cmd_valid = full_r;
  assign cmd       = cmd_r;

  assign ra = (in_word.first_register < 5'(REG_COUNT)) ?
              regs_r[in_word.first_register] : 16'd0;
  assign rb = (in_word.second_register < 5'(REG_COUNT)) ?
              regs_r[in_word.second_register] : 16'd0;

  always_comb begin
    cmd_nxt = '0;
    cmd_nxt.operation = in_word.operation;
    cmd_nxt.dest_reg  = in_word.first_register;
    cmd_nxt.dest_ok   = in_word.first_register < 5'(REG_COUNT);
    cmd_nxt.reg_a     = ra;
    case (in_word.operation)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        cmd_nxt.pops  = 2'd2;
        cmd_nxt.push  = 1'b1;
        cmd_nxt.arith = 1'b1;
      end
      OP_POP_REG, OP_PRINT_Q, OP_CHAR_Q: cmd_nxt.pops = 2'd1;
      OP_PUSH_REG: begin
        cmd_nxt.push       = 1'b1;
        cmd_nxt.push_value = ra;
      end
      OP_PUSH_CONST: begin
        cmd_nxt.push       = 1'b1;
        cmd_nxt.push_value = in_word.immediate_value;
      end
      OP_JUMP: cmd_nxt.branch_taken = 1'b1;
      OP_JZ:   cmd_nxt.branch_taken = (ra == 16'd0);
      OP_JEQ:  cmd_nxt.branch_taken = (ra == rb);
      OP_JGT:  cmd_nxt.branch_taken = (ra > rb);
      OP_QUIT: cmd_nxt.halt = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    full_nxt = full_r;
    busy_nxt = busy_r;
    if (cmd_take) begin
      full_nxt = 1'b0;
    end
    if (acc) begin
      full_nxt = 1'b1;
      busy_nxt = 1'b1;
    end else if (wb_en) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      busy_r <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) regs_r[i] <= '0;
    end else begin
      full_r <= full_nxt;
      busy_r <= busy_nxt;
      if (wb_en && wb_reg < 5'(REG_COUNT)) begin
        regs_r[wb_reg] <= wb_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ----- design/qmeu_divider.sv -----
module qmeu_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient,
  output logic [15:0] remainder
);
  import qmeu_pkg::*;

  logic [15:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] d_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic [16:0] trial;
  logic [16:0] diff;

  assign trial = {rem_r[15:0], q_r[15]};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (start) begin
      q_nxt   = dividend;
      rem_nxt = '0;
      cnt_nxt = 5'd16;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[16]) begin
        rem_nxt = diff;
        q_nxt   = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        run_nxt = 1'b0;
      end
    end
  end

  assign done      = run_r && cnt_r == 5'd1;
  assign quotient  = (d_r == 16'd0) ? 16'd0 : q_nxt;
  assign remainder = (d_r == 16'd0) ? 16'd0 : rem_nxt[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

endmodule

// ----- design/qmeu_back.sv -----
module qmeu_back #(
  parameter int QUEUE_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_take,
  input  qmeu_pkg::cmd_t     cmd,
  output logic               wb_en,
  output logic [4:0]         wb_reg,
  output logic [15:0]        wb_value,
  output logic               out_valid,
  input  logic               out_stall,
  output qmeu_pkg::out_word_t out_word
);
  import qmeu_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [15:0]   mem [QUEUE_DEPTH];
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  state_t        state_r, state_nxt;
  cmd_t          c_r;
  logic [15:0]   x_r, x_nxt, y_r, y_nxt, res_r, res_nxt;
  logic [15:0]   rd_data;
  logic          rd_ok_r;
  logic          err_r, err_nxt;
  logic          ov_r, ov_nxt;
  out_word_t     ow_r, ow_nxt;
  logic          pop_en, push_en;
  logic [15:0]   pop_val;
  logic          div_start, div_done;
  logic [15:0]   div_q, div_rem;
  logic [31:0]   prod;

  qmeu_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(x_r), .divisor(y_nxt),
    .done(div_done), .quotient(div_q), .remainder(div_rem)
  );

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    logic [AW-1:0] n;
    n = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    return n;
  endfunction

  // Read data for the head entry is registered.
  always_ff @(posedge clk) begin
    rd_data <= mem[head_nxt];
    if (push_en) begin
      mem[tail_r] <= res_nxt;
    end
  end

  assign pop_val = rd_ok_r ? rd_data : 16'd0;
  assign prod    = x_r * y_r;
  assign cmd_take = (state_r == ST_IDLE) && cmd_valid && !ov_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (cmd_take) begin
        if (cmd.pops != 2'd0)  state_nxt = ST_POP1;
        else if (cmd.push)     state_nxt = ST_PUSH;
        else                   state_nxt = ST_DONE;
      end
      ST_POP1: state_nxt = (c_r.pops == 2'd2) ? ST_POP2 : ST_DONE;
      ST_POP2: state_nxt = (c_r.operation == OP_DIV || c_r.operation == OP_MOD) ?
                           ST_DIV : ST_PUSH;
      ST_DIV:  if (div_done) state_nxt = ST_PUSH;
      ST_PUSH: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_en    = 1'b0;
    push_en   = 1'b0;
    div_start = 1'b0;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    res_nxt   = res_r;
    err_nxt   = err_r;
    ov_nxt    = ov_r;
    ow_nxt    = ow_r;
    wb_en     = 1'b0;
    wb_reg    = c_r.dest_reg;
    wb_value  = x_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (cmd_take) begin
          err_nxt = 1'b0;
          res_nxt = cmd.push_value;
        end
      end
      ST_POP1, ST_POP2: begin
        pop_en = rd_ok_r;
        if (!rd_ok_r) err_nxt = 1'b1;
        if (state_r == ST_POP1) x_nxt = pop_val;
        else y_nxt = pop_val;
        if (state_r == ST_POP2) begin
          div_start = (c_r.operation == OP_DIV || c_r.operation == OP_MOD);
          case (c_r.operation)
            OP_ADD:  res_nxt = x_r + pop_val;
            OP_SUB:  res_nxt = x_r - pop_val;
            default: res_nxt = res_r;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt = (c_r.operation == OP_DIV) ? div_q : div_rem;
        end
      end
      ST_PUSH: begin
        if (c_r.operation == OP_MUL) res_nxt = prod[15:0];
        if (count_r == CW'(QUEUE_DEPTH)) err_nxt = 1'b1;
        else push_en = 1'b1;
      end
      ST_DONE: begin
        wb_en  = 1'b1;
        wb_reg = (c_r.operation == OP_POP_REG && c_r.dest_ok) ? c_r.dest_reg : 5'd31;
        ov_nxt = 1'b1;
        ow_nxt = '0;
        ow_nxt.branch_taken = c_r.branch_taken;
        ow_nxt.halt         = c_r.halt;
        ow_nxt.queue_error  = err_r;
        case (c_r.operation)
          OP_PRINT_Q: begin
            ow_nxt.print_valid = 1'b1;
            ow_nxt.print_value = x_r;
          end
          OP_PRINT_REG: begin
            ow_nxt.print_valid = 1'b1;
            ow_nxt.print_value = c_r.reg_a;
          end
          OP_CHAR_Q: begin
            ow_nxt.print_valid   = 1'b1;
            ow_nxt.print_as_char = 1'b1;
            ow_nxt.print_value   = x_r & BYTE_MASK;
          end
          OP_CHAR_REG: begin
            ow_nxt.print_valid   = 1'b1;
            ow_nxt.print_as_char = 1'b1;
            ow_nxt.print_value   = c_r.reg_a & BYTE_MASK;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (pop_en) begin
      head_nxt = adv(head_r);
    end
    if (push_en) begin
      tail_nxt = adv(tail_r);
    end
    count_nxt = count_r + CW'(push_en) - CW'(pop_en);
  end

  // The head entry is valid once the queue holds a value and any push to
  // it has landed in the memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      rd_ok_r <= (count_nxt != '0) && !(push_en && count_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    res_r <= res_nxt;
    err_r <= err_nxt;
    ow_r  <= ow_nxt;
    if (cmd_take) begin
      c_r <= cmd;
    end
  end

  assign out_valid = ov_r;
  assign out_word  = ow_r;

endmodule

// ----- bench/tb_queue_machine_execute_unit.sv -----
`timescale 1ns / 1ps

module tb_queue_machine_execute_unit;
  import qmeu_pkg::*;

  localparam int DEPTH = 4096;
  localparam int QUIET_TAIL = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  queue_machine_execute_unit #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #5 clk = ~clk;

  in_word_t pending_words[$];
  bit pending_drain[$];
  out_word_t expected_results[$];
  logic [15:0] value_fifo[$];
  logic [15:0] regs[REG_COUNT];
  bit fifo_fault;
  int error_count = 0;
  int words_taken = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic in_fire = 1'b0;

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [15:0] fifo_take();
    if (value_fifo.size() == 0) begin
      fifo_fault = 1'b1;
      return 16'd0;
    end
    return value_fifo.pop_front();
  endfunction

  function automatic void fifo_put(logic [15:0] v);
    if (value_fifo.size() >= DEPTH) fifo_fault = 1'b1;
    else value_fifo.insert(value_fifo.size(), v);
  endfunction

  function automatic logic [15:0] reg_value(logic [4:0] idx);
    return (idx < REG_COUNT) ? regs[idx] : 16'd0;
  endfunction

  function automatic out_word_t execute_word(in_word_t w);
    out_word_t r;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] res;
    r = '0;
    fifo_fault = 1'b0;
    case (w.operation)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        x = fifo_take();
        y = fifo_take();
        case (w.operation)
          OP_ADD: res = x + y;
          OP_SUB: res = {16'd0, x} - {16'd0, y};
          OP_MUL: res = x * y;
          OP_DIV: res = (y == 0) ? 32'd0 : x / y;
          default: res = (y == 0) ? 32'd0 : x % y;
        endcase
        fifo_put(res[15:0]);
      end
      OP_POP_REG: begin
        x = fifo_take();
        if (w.first_register < REG_COUNT) regs[w.first_register] = x;
      end
      OP_PUSH_REG: fifo_put(reg_value(w.first_register));
      OP_PRINT_Q: begin
        r.print_valid = 1'b1;
        r.print_value = fifo_take();
      end
      OP_PRINT_REG: begin
        r.print_valid = 1'b1;
        r.print_value = reg_value(w.first_register);
      end
      OP_CHAR_Q: begin
        r.print_valid = 1'b1;
        r.print_as_char = 1'b1;
        r.print_value = fifo_take() & BYTE_MASK;
      end
      OP_CHAR_REG: begin
        r.print_valid = 1'b1;
        r.print_as_char = 1'b1;
        r.print_value = reg_value(w.first_register) & BYTE_MASK;
      end
      OP_JUMP: r.branch_taken = 1'b1;
      OP_JZ: r.branch_taken = (reg_value(w.first_register) == 0);
      OP_JEQ: r.branch_taken = (reg_value(w.first_register) == reg_value(w.second_register));
      OP_JGT: r.branch_taken = (reg_value(w.first_register) > reg_value(w.second_register));
      OP_PUSH_CONST: fifo_put(w.immediate_value);
      OP_QUIT: r.halt = 1'b1;
      default: ;
    endcase
    r.queue_error = fifo_fault;
    return r;
  endfunction

  task automatic add_word(op_t op, logic [4:0] ra, logic [4:0] rb, logic [15:0] imm,
                          bit drain = 0);
    in_word_t w;
    w.operation = op;
    w.first_register = ra;
    w.second_register = rb;
    w.immediate_value = imm;
    pending_words.insert(pending_words.size(), w);
    pending_drain.insert(pending_drain.size(), drain);
  endtask

  task automatic add_random_word();
    in_word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w.first_register = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
                                                  : 5'($urandom_range(0, 25));
    w.second_register = 5'($urandom_range(0, 31));
    case ($urandom_range(0, 5))
      0: w.immediate_value = 16'd0;
      1: w.immediate_value = 16'hffff;
      2: w.immediate_value = 16'($urandom_range(0, 15));
      default: w.immediate_value = 16'($urandom);
    endcase
    if (pick < 25) w.operation = OP_PUSH_CONST;
    else if (pick < 33) w.operation = OP_PUSH_REG;
    else if (pick < 53) w.operation = 5'($urandom_range(OP_ADD, OP_MOD));
    else if (pick < 60) w.operation = OP_POP_REG;
    else if (pick < 94) w.operation = 5'($urandom_range(OP_PRINT_Q, OP_NOP));
    else w.operation = 5'($urandom_range(0, 31));
    pending_words.insert(pending_words.size(), w);
    pending_drain.insert(pending_drain.size(), 1'b0);
  endtask

  always @(posedge clk) begin
    in_fire <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_results.insert(expected_results.size(), execute_word(in_word));
      words_taken++;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_taken >= 300) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result word", out_word.print_value, 16'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_word.print_valid !== want.print_valid)
          report_mismatch("print_valid", out_word.print_valid, want.print_valid);
        if (out_word.print_as_char !== want.print_as_char)
          report_mismatch("print_as_char", out_word.print_as_char, want.print_as_char);
        if (out_word.print_value !== want.print_value)
          report_mismatch("print_value", out_word.print_value, want.print_value);
        if (out_word.branch_taken !== want.branch_taken)
          report_mismatch("branch_taken", out_word.branch_taken, want.branch_taken);
        if (out_word.halt !== want.halt)
          report_mismatch("halt", out_word.halt, want.halt);
        if (out_word.queue_error !== want.queue_error)
          report_mismatch("queue_error", out_word.queue_error, want.queue_error);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_drain[0] && expected_results.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        in_word <= pending_words.pop_front();
        void'(pending_drain.pop_front());
        in_valid <= 1'b1;
        if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 16);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (recv_gap > 0) recv_gap--;
      else if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
        recv_gap = $urandom_range(1, 16);
      out_stall <= (hold_left > 0) || (recv_gap > 0);
    end
  end

  initial begin
    for (int i = 0; i < REG_COUNT; i++) regs[i] = 16'd0;

    // Directed opening: extremes, every operation and the corner cases.
    add_word(OP_ADD, 0, 0, 0);
    add_word(OP_PUSH_CONST, 0, 0, 16'hffff);
    add_word(OP_PUSH_CONST, 0, 0, 16'h0000);
    add_word(OP_DIV, 0, 0, 0);
    add_word(OP_PUSH_CONST, 0, 0, 16'd0);
    add_word(OP_MOD, 0, 0, 0);
    add_word(OP_PUSH_CONST, 0, 0, 16'd1);
    add_word(OP_PUSH_CONST, 0, 0, 16'd2);
    add_word(OP_SUB, 0, 0, 0);
    add_word(OP_PUSH_CONST, 0, 0, 16'hffff);
    add_word(OP_MUL, 0, 0, 0);
    add_word(OP_POP_REG, 25, 0, 0);
    add_word(OP_PUSH_REG, 25, 0, 0);
    add_word(OP_POP_REG, 31, 0, 0);
    add_word(OP_PUSH_REG, 31, 0, 0);
    add_word(OP_PRINT_Q, 0, 0, 0);
    add_word(OP_PRINT_REG, 25, 0, 0);
    add_word(OP_CHAR_REG, 25, 0, 0);
    add_word(OP_PUSH_CONST, 0, 0, 16'h1261);
    add_word(OP_CHAR_Q, 0, 0, 0);
    add_word(OP_JUMP, 0, 0, 0);
    add_word(OP_JZ, 0, 0, 0);
    add_word(OP_JEQ, 25, 31, 0);
    add_word(OP_JGT, 25, 0, 0);
    add_word(OP_QUIT, 0, 0, 0);
    add_word(OP_NOP, 0, 0, 0);
    add_word(op_t'(5'd31), 0, 0, 0);

    add_word(OP_PUSH_CONST, 0, 0, 16'h00aa, 1'b1);
    for (int i = 0; i < 1000; i++) add_random_word();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (60) @(posedge clk);
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout at %0t", $realtime);
    $display("== FAIL ==");
    $finish;
  end

endmodule
